FILE: src/smm_pkg.sv
package smm_pkg;

   localparam int MAX_VALUES = 32;
   localparam int VALUE_BITS = 16;
   localparam int COUNT_BITS = $clog2(MAX_VALUES + 1);
   localparam int INDEX_BITS = $clog2(MAX_VALUES);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic      load;
      value_type value;
   } smm_bcast_type;

   typedef struct packed {
      value_type         min_value;
      value_type         max_value;
      logic [VALUE_BITS:0] median_twice;
   } smm_result_type;

endpackage

FILE: src/smm_cell.sv
module smm_cell import smm_pkg::*; (
   input  logic          clock,
   input  smm_bcast_type bcast,
   input  logic          occupied,
   input  value_type     prev_value,
   input  logic          prev_greater,
   output value_type     value,
   output logic          greater
);

   value_type value_ff;
   value_type value_in;

   assign greater = !occupied || (value_ff > bcast.value);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (bcast.load && greater) begin
         value_in = prev_greater ? prev_value : bcast.value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: src/smm_select.sv
module smm_select import smm_pkg::*; (
   input  value_type      cell_value [MAX_VALUES],
   input  count_type      count,
   output smm_result_type result
);

   count_type half;
   count_type last_pos;
   index_type lo_idx;
   index_type hi_idx;
   index_type max_idx;

   always_comb begin
      half     = count >> 1;
      last_pos = count - count_type'(1);
      max_idx  = last_pos[INDEX_BITS-1:0];
      hi_idx   = half[INDEX_BITS-1:0];
      if (count[0]) begin
         lo_idx = half[INDEX_BITS-1:0];
      end else begin
         lo_idx = last_pos[INDEX_BITS:1];
      end
      result.min_value    = cell_value[0];
      result.max_value    = cell_value[max_idx];
      result.median_twice = {1'b0, cell_value[lo_idx]} + {1'b0, cell_value[hi_idx]};
   end

endmodule

FILE: src/set_min_max_median_core.sv
// Sorted insertion chain for one set of values. Each accepted value is placed
// into a row of MAX_VALUES cells in ascending order, so a set loads at one
// value per cycle outside the finish state. The value marked last is followed by a
// finish state in which the minimum, maximum and doubled median are picked
// from the chain into the output register; that state waits while an earlier
// result is still untaken. Values beyond MAX_VALUES are dropped and reported
// as overflow. A new set may start loading while the previous result waits.
module set_min_max_median_core import smm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_stock_value,
   input  logic        req_last_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_min_value,
   output logic [15:0] rsp_max_value,
   output logic [16:0] rsp_median_twice,
   output logic [5:0]  rsp_value_count,
   output logic        rsp_overflow
);

   localparam logic ST_LOAD   = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic           state_ff, state_in;
   count_type      count_ff, count_in;
   logic           dropped_ff, dropped_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      min_ff, max_ff;
   logic [VALUE_BITS:0] med_ff;
   count_type      out_count_ff;
   logic           out_over_ff;

   logic           accept;
   logic           full;
   logic           handoff;
   smm_bcast_type  bcast;
   value_type      cell_value [MAX_VALUES];
   logic [MAX_VALUES-1:0] cell_greater;
   smm_result_type result;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == count_type'(MAX_VALUES));
   assign handoff   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign bcast.load  = accept && !full;
   assign bcast.value = value_type'(req_stock_value);

   for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
      if (i == 0) begin : g_head
         smm_cell u_cell (
            .clock        (clock),
            .bcast        (bcast),
            .occupied     (count_ff != count_type'(0)),
            .prev_value   (bcast.value),
            .prev_greater (1'b0),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
         );
      end else begin : g_body
         smm_cell u_cell (
            .clock        (clock),
            .bcast        (bcast),
            .occupied     (count_type'(i) < count_ff),
            .prev_value   (cell_value[i-1]),
            .prev_greater (cell_greater[i-1]),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
         );
      end
   end

   smm_select u_select (
      .cell_value (cell_value),
      .count      (count_ff),
      .result     (result)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + count_type'(1);
               end
               if (req_last_value) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (handoff) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               dropped_in   = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (handoff) begin
         min_ff       <= result.min_value;
         max_ff       <= result.max_value;
         med_ff       <= result.median_twice;
         out_count_ff <= count_ff;
         out_over_ff  <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_value    = 16'(min_ff);
   assign rsp_max_value    = 16'(max_ff);
   assign rsp_median_twice = 17'(med_ff);
   assign rsp_value_count  = 6'(out_count_ff);
   assign rsp_overflow     = out_over_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_VALUES))
      else $error("fill count beyond capacity");

   a_finish_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (count_ff != count_type'(0)))
      else $error("result pick with empty chain");

   a_last_to_finish: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_value) |=> (state_ff == ST_FINISH))
      else $error("last transaction did not start result pick");

   a_handoff_clears: assert property (@(posedge clock) disable iff (reset)
      handoff |=> (rsp_valid_ff && count_ff == count_type'(0) && !dropped_ff))
      else $error("result handoff did not clear the set");
`endif

endmodule
